@@ sv/vt4_pkg.sv @@
// Shared types and constants for the 4x4 vertex transform pipeline.
// No dependencies; used by every module of the block.
package vt4_pkg;

  localparam int WORD_W       = 32;
  localparam int ENTRIES      = 16;
  localparam int IDX_W        = 4;
  localparam int COLS         = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int S_TDATA_W    = 136;
  localparam int M_TDATA_W    = 128;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_XFORM = 1'b1
  } action_t;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [ENTRIES-1:0] matrix_t;

  // per-stage load enables and matrix write strobe
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic wr;
  } pipe_en_t;

  function automatic logic signed [2*WORD_W-1:0] smul(input logic signed [WORD_W-1:0] a,
                                                       input logic signed [WORD_W-1:0] b);
    smul = $signed({{WORD_W{a[WORD_W-1]}}, a}) * $signed({{WORD_W{b[WORD_W-1]}}, b});
  endfunction

endpackage

@@ sv/vt4_matrix.sv @@
// Matrix store: sixteen 32-bit entries, cleared by reset, written one word at a time.
// Depends on vt4_pkg.
module vt4_matrix (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr,
  input  logic [vt4_pkg::IDX_W-1:0] wr_idx,
  input  vt4_pkg::word_t            wr_value,
  output vt4_pkg::matrix_t          mat
);

  vt4_pkg::matrix_t entries;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= '0;
    end else if (wr) begin
      entries[wr_idx] <= wr_value;
    end
  end

  assign mat = entries;

endmodule

@@ sv/vt4_column.sv @@
// One output column: three products, rounding, adder tree and saturation over
// four register stages. Depends on vt4_pkg.
module vt4_column #(
  parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  vt4_pkg::pipe_en_t      en,
  input  logic signed [31:0]     px,
  input  logic signed [31:0]     py,
  input  logic signed [31:0]     pz,
  input  logic signed [31:0]     m0,
  input  logic signed [31:0]     m1,
  input  logic signed [31:0]     m2,
  input  logic signed [31:0]     m3,
  output logic signed [31:0]     result
);

  localparam int PW = 2 * vt4_pkg::WORD_W;
  localparam int RW = PW - FRAC_BITS;
  localparam int SW = RW + 2;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-32){1'b0}}, 32'h7fff_ffff};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-32){1'b1}}, 32'h8000_0000};

  logic signed [PW-1:0] p0, p1, p2;
  logic signed [31:0]   b2, b3;
  logic signed [RW-1:0] r0, r1, r2;
  logic signed [RW:0]   sa, sb;
  logic [PW-1:0]        t0, t1, t2;
  logic signed [SW-1:0] sum;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p0 <= vt4_pkg::smul(px, m0);
      p1 <= vt4_pkg::smul(py, m1);
      p2 <= vt4_pkg::smul(pz, m2);
      b2 <= m3;
    end
  end

  // round to nearest, ties up
  assign t0 = p0 + HALF;
  assign t1 = p1 + HALF;
  assign t2 = p2 + HALF;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      r0 <= $signed(t0[PW-1:FRAC_BITS]);
      r1 <= $signed(t1[PW-1:FRAC_BITS]);
      r2 <= $signed(t2[PW-1:FRAC_BITS]);
      b3 <= b2;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      sa <= $signed({r0[RW-1], r0}) + $signed({r1[RW-1], r1});
      sb <= $signed({r2[RW-1], r2}) + $signed({{(RW+1-32){b3[31]}}, b3});
    end
  end

  assign sum = $signed({sa[RW], sa}) + $signed({sb[RW], sb});

  always_ff @(posedge clk) begin
    if (en.s5) begin
      if (sum > SAT_HI) begin
        result <= 32'sh7fff_ffff;
      end else if (sum < SAT_LO) begin
        result <= 32'sh8000_0000;
      end else begin
        result <= sum[31:0];
      end
    end
  end

endmodule

@@ sv/vt4_pipe_ctrl.sv @@
// Valid/ready chain for the five-stage pipeline; stages fill bubbles independently.
// Depends on vt4_pkg.
module vt4_pipe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              s1_xform,
  output logic              m_tvalid,
  input  logic              m_tready,
  output vt4_pkg::pipe_en_t en
);

  logic v1, v2, v3, v4, v5;
  logic ready1, ready2, ready3, ready4, ready5;
  logic fire1;

  always_comb begin
    ready5 = !v5 || m_tready;
    ready4 = !v4 || ready5;
    ready3 = !v3 || ready4;
    ready2 = !v2 || ready3;
    // a write leaves stage 1 at once, a transform needs room downstream
    fire1  = v1 && (!s1_xform || ready2);
    ready1 = !v1 || fire1;
  end

  always_comb begin
    en.s1 = ready1;
    en.s2 = ready2;
    en.s3 = ready3;
    en.s4 = ready4;
    en.s5 = ready5;
    en.wr = v1 && !s1_xform;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (ready1) v1 <= s_tvalid;
      if (ready2) v2 <= v1 && s1_xform;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
      if (ready5) v5 <= v4;
    end
  end

  assign s_tready = ready1;
  assign m_tvalid = v5;

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted word did not enter stage 1");

  a_xform_holds_s1: assert property (@(posedge clk) disable iff (rst)
    v1 && s1_xform && !ready2 |=> v1 && $stable(s1_xform))
    else $error("stalled transform left stage 1");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    v1 && s1_xform && v2 && v3 && v4 && v5 && !m_tready |-> !s_tready)
    else $error("input accepted with full stalled pipeline");

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    v2 && !ready3 |=> v2)
    else $error("stage 2 dropped a word under stall");

endmodule

@@ sv/vertex_transform_4x4.sv @@
// Top level of the 4x4 homogeneous vertex transform: input stage, matrix store,
// pipeline control and four column datapaths. Depends on vt4_pkg and all vt4_ modules.
//
// Takes one word per cycle while s_tready is high. A write word (action 0) stores one
// matrix entry as it leaves the input register and yields nothing. A transform word
// (action 1) passes from the input register through the register stages behind it
// and then shows x, y, z, w on m_tdata; the result uses every write that came before it.
// These stages are the 32x32 multipliers, rounding, the first adder level, and the last
// adder level with saturation. While m_tready is low, bubbles close up; s_tready drops
// only when a transform in the input register cannot move on.
// The matrix is all zero after reset.
module vertex_transform_4x4 #(
  parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // entry_index[3:0], entry_value[35:4], point_x[67:36], point_y[99:68],
  // point_z[131:100], zero[135:132]
  input  logic [vt4_pkg::S_TDATA_W-1:0] s_tdata,
  // action[0]
  input  logic [0:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic [vt4_pkg::M_TDATA_W-1:0] m_tdata
);

  vt4_pkg::pipe_en_t en;
  vt4_pkg::action_t  act1;
  logic [vt4_pkg::IDX_W-1:0] idx1;
  vt4_pkg::word_t    val1;
  logic signed [31:0] px1, py1, pz1;
  vt4_pkg::matrix_t  mat;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      act1 <= vt4_pkg::action_t'(s_tuser[0]);
      idx1 <= s_tdata[3:0];
      val1 <= s_tdata[35:4];
      px1  <= $signed(s_tdata[67:36]);
      py1  <= $signed(s_tdata[99:68]);
      pz1  <= $signed(s_tdata[131:100]);
    end
  end

  vt4_pipe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s1_xform (act1 == vt4_pkg::ACT_XFORM),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .en       (en)
  );

  vt4_matrix u_matrix (
    .clk      (clk),
    .rst      (rst),
    .wr       (en.wr),
    .wr_idx   (idx1),
    .wr_value (val1),
    .mat      (mat)
  );

  for (genvar c = 0; c < vt4_pkg::COLS; c++) begin : g_col
    vt4_column #(
      .FRAC_BITS (FRAC_BITS)
    ) u_col (
      .clk    (clk),
      .en     (en),
      .px     (px1),
      .py     (py1),
      .pz     (pz1),
      .m0     ($signed(mat[c])),
      .m1     ($signed(mat[4 + c])),
      .m2     ($signed(mat[8 + c])),
      .m3     ($signed(mat[12 + c])),
      .result (m_tdata[c*32 +: 32])
    );
  end

endmodule

@@ sim/vertex_transform_4x4_tb.sv @@
// Self-checking bench for vertex_transform_4x4: directed matrix loads and transforms,
// then ~900 random words under random stalls, checked against a Q16.16 predictor.
// Depends on vt4_pkg and the vertex_transform_4x4 RTL.
module vertex_transform_4x4_tb;

  localparam int FRAC       = vt4_pkg::FRAC_BITS_DEF;
  localparam int N_RANDOM   = 900;
  localparam int LONG_HOLD  = 200;
  localparam int DRAIN_WAIT = 16;
  localparam int MAX_FAILS  = 10;

  localparam vt4_pkg::word_t Q_ONE = 32'h0001_0000;
  localparam vt4_pkg::word_t W_MAX = 32'h7FFF_FFFF;
  localparam vt4_pkg::word_t W_MIN = 32'h8000_0000;
  localparam vt4_pkg::word_t W_ONES = 32'hFFFF_FFFF;

  localparam logic [vt4_pkg::IDX_W-1:0] M00 = 4'd0;
  localparam logic [vt4_pkg::IDX_W-1:0] M11 = 4'd5;
  localparam logic [vt4_pkg::IDX_W-1:0] M13 = 4'd7;
  localparam logic [vt4_pkg::IDX_W-1:0] M22 = 4'd10;
  localparam logic [vt4_pkg::IDX_W-1:0] M30 = 4'd12;
  localparam logic [vt4_pkg::IDX_W-1:0] M33 = 4'd15;

  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  typedef struct packed {
    vt4_pkg::word_t w;
    vt4_pkg::word_t z;
    vt4_pkg::word_t y;
    vt4_pkg::word_t x;
  } vec_t;

  typedef struct packed {
    vt4_pkg::action_t          act;
    logic [vt4_pkg::IDX_W-1:0] idx;
    vt4_pkg::word_t            val;
    vt4_pkg::word_t            px;
    vt4_pkg::word_t            py;
    vt4_pkg::word_t            pz;
    logic                      known;
    vec_t                      want;
  } row_t;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [vt4_pkg::S_TDATA_W-1:0] s_tdata;
  logic [0:0]                    s_tuser;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [vt4_pkg::M_TDATA_W-1:0] m_tdata;

  vt4_pkg::word_t mat_shadow [vt4_pkg::ENTRIES];
  vec_t  pending_vecs [$];
  int    fail_count = 0;
  bit    hold_rx = 1'b0;
  bit    pace_on = 1'b1;

  vertex_transform_4x4 u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // exact product, rounded half up to FRAC fraction bits
  function automatic logic signed [63:0] mul_q(vt4_pkg::word_t a, vt4_pkg::word_t b);
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic signed [63:0] p;
    sa = $signed(a);
    sb = $signed(b);
    p = sa * sb;
    p = p + (64'sd1 <<< (FRAC - 1));
    return p >>> FRAC;
  endfunction

  function automatic vt4_pkg::word_t clamp32(logic signed [63:0] s);
    if (s > SAT_HI) return W_MAX;
    if (s < SAT_LO) return W_MIN;
    return s[31:0];
  endfunction

  function automatic vec_t xform_point(vt4_pkg::word_t px, vt4_pkg::word_t py,
                                       vt4_pkg::word_t pz);
    vt4_pkg::word_t     col [vt4_pkg::COLS];
    logic signed [63:0] bias;
    logic signed [63:0] acc;
    for (int c = 0; c < vt4_pkg::COLS; c++) begin
      bias = $signed(mat_shadow[12 + c]);
      acc = mul_q(px, mat_shadow[c]) + mul_q(py, mat_shadow[4 + c])
          + mul_q(pz, mat_shadow[8 + c]) + bias;
      col[c] = clamp32(acc);
    end
    return {col[3], col[2], col[1], col[0]};
  endfunction

  // mostly small Q16.16 values so that not every column saturates
  function automatic vt4_pkg::word_t rand_q();
    case ($urandom_range(0, 19))
      0: return W_MAX;
      1: return W_MIN;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic row_t row(vt4_pkg::action_t act, logic [vt4_pkg::IDX_W-1:0] idx,
                               vt4_pkg::word_t val, vt4_pkg::word_t px,
                               vt4_pkg::word_t py, vt4_pkg::word_t pz,
                               logic known, vec_t want);
    return {act, idx, val, px, py, pz, known, want};
  endfunction

  task automatic idle_sender(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(row_t r);
    s_tvalid <= 1'b1;
    s_tuser  <= r.act;
    s_tdata  <= {4'b0, r.pz, r.py, r.px, r.val, r.idx};
    do @(posedge clk); while (!s_tready);
    if (r.act == vt4_pkg::ACT_WRITE)
      mat_shadow[r.idx] = r.val;
    else
      pending_vecs.push_back(r.known ? r.want : xform_point(r.px, r.py, r.pz));
  endtask

  task automatic check_field(string tag, vt4_pkg::word_t want, vt4_pkg::word_t got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_FAILS)
        $display("mismatch out_%s: expected %h actual %h", tag, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    vec_t got;
    vec_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_vecs.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_FAILS) $display("unexpected result word %h", m_tdata);
      end else begin
        want = pending_vecs.pop_front();
        check_field("x", want.x, got.x);
        check_field("y", want.y, got.y);
        check_field("z", want.z, got.z);
        check_field("w", want.w, got.w);
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    bit long_done;
    long_done = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx && !long_done) begin
        long_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (pace_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // sender
  initial begin
    row_t r;
    row_t steps [$];
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= vt4_pkg::ACT_WRITE;
    for (int e = 0; e < vt4_pkg::ENTRIES; e++) mat_shadow[e] = '0;

    // zero matrix after reset, extreme points
    steps.push_back(row(vt4_pkg::ACT_XFORM, M00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, '0));
    steps.push_back(row(vt4_pkg::ACT_XFORM, M33, W_MAX, W_MIN, W_MAX, W_MIN, 1'b1, '0));
    // identity; point fields of writes are junk
    steps.push_back(row(vt4_pkg::ACT_WRITE, M00, Q_ONE, W_ONES, W_ONES, W_ONES, 1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_WRITE, M11, Q_ONE, W_ONES, W_ONES, W_ONES, 1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_WRITE, M22, Q_ONE, W_ONES, W_ONES, W_ONES, 1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_WRITE, M33, Q_ONE, W_ONES, W_ONES, W_ONES, 1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_XFORM, M13, W_ONES, 32'h0001_8000, 32'hFFFE_0000,
                        32'h0003_4000, 1'b1,
                        {Q_ONE, 32'h0003_4000, 32'hFFFE_0000, 32'h0001_8000}));
    steps.push_back(row(vt4_pkg::ACT_XFORM, M00, 32'h0, W_MAX, W_MIN, W_MAX,
                        1'b1, {Q_ONE, W_MAX, W_MIN, W_MAX}));
    // translation drives x into saturation both ways
    steps.push_back(row(vt4_pkg::ACT_WRITE, M30, W_MAX, 32'h0, 32'h0, 32'h0, 1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_XFORM, M00, 32'h0, W_MAX, 32'h0, 32'h0,
                        1'b1, {Q_ONE, 32'h0, 32'h0, W_MAX}));
    steps.push_back(row(vt4_pkg::ACT_WRITE, M30, W_MIN, 32'h0, 32'h0, 32'h0, 1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_XFORM, M00, 32'h0, W_MIN, 32'h0, 32'h0,
                        1'b1, {Q_ONE, 32'h0, 32'h0, W_MIN}));
    steps.push_back(row(vt4_pkg::ACT_WRITE, M00, W_MIN, 32'h0, 32'h0, 32'h0, 1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_XFORM, M00, 32'h0, W_MIN, 32'h0, 32'h0,
                        1'b1, {Q_ONE, 32'h0, 32'h0, W_MAX}));
    // rounding ties on the smallest entry
    steps.push_back(row(vt4_pkg::ACT_WRITE, M00, 32'h1, 32'h0, 32'h0, 32'h0, 1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_WRITE, M30, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_XFORM, M00, 32'h0, 32'h0000_8000, 32'h0, 32'h0,
                        1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_XFORM, M00, 32'h0, 32'hFFFF_8000, 32'h0, 32'h0,
                        1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_XFORM, M00, 32'h0, 32'h0000_7FFF, 32'h0, 32'h0,
                        1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_WRITE, M13, W_ONES, W_MAX, W_MIN, W_ONES, 1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_XFORM, M13, W_MIN, 32'h0, Q_ONE, 32'h0, 1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_WRITE, M33, W_MAX, 32'h0, 32'h0, 32'h0, 1'b0, '0));
    steps.push_back(row(vt4_pkg::ACT_XFORM, M00, 32'h0, W_MIN, W_MIN, W_MIN, 1'b0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[k]) begin
      if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 6));
      send_word(steps[k]);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_rx = 1'b1;
      if (i == 500) begin
        idle_sender(1);
        while (pending_vecs.size() != 0) @(posedge clk);
      end
      if (i == 750) pace_on = 1'b0;
      // keep offering back to back while the receiver holds off
      if (pace_on && !(i >= 300 && i < 340) && $urandom_range(0, 5) == 0)
        idle_sender($urandom_range(1, 6));
      r.act   = ($urandom_range(0, 3) == 0) ? vt4_pkg::ACT_WRITE : vt4_pkg::ACT_XFORM;
      r.idx   = vt4_pkg::IDX_W'($urandom_range(0, vt4_pkg::ENTRIES - 1));
      r.val   = rand_q();
      r.px    = rand_q();
      r.py    = rand_q();
      r.pz    = rand_q();
      r.known = 1'b0;
      r.want  = '0;
      send_word(r);
    end

    idle_sender(1);
    while (pending_vecs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
